// ===== hdl/sqe_pkg.sv =====
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared types and codes of the stack/queue engine: operation codes, status
// codes, the controller state type and the default store depth.
// ----------------------------------------------------------------------------
package sqe_pkg;

    localparam int SQE_DEPTH   = 32;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 40;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_PUSH      = 3'd0;
    localparam op_t OP_PRINT_ALL = 3'd1;
    localparam op_t OP_PEEK      = 3'd2;
    localparam op_t OP_POP       = 3'd3;
    localparam op_t OP_SWAP      = 3'd4;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_EMPTY = 2'd1;
    localparam status_t STAT_SHORT = 2'd2;
    localparam status_t STAT_FULL  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEEK,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_SWAP_C,
        ST_PRINT,
        ST_RESP
    } sqe_state_t;

endpackage

// ===== hdl/sqe_ram.sv =====
// ----------------------------------------------------------------------------
// sqe_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/stack_queue_engine.sv =====
// ----------------------------------------------------------------------------
// stack_queue_engine
// Bounded stack/queue of signed 32-bit values kept in a circular buffer RAM.
// ----------------------------------------------------------------------------
// The engine keeps up to DEPTH signed 32-bit entries in a synchronous RAM used
// as a circular buffer, with a head pointer (the front entry) and an entry
// count in registers. Pop, peek and swap work on the front entry. A push adds
// the value at the front when queue_mode is 0 (stack) or at the back when it
// is 1 (queue); pop drops the front entry, peek returns it, swap exchanges the
// two front entries, and print-all returns every entry from front to back
// with tlast on the back one. Every other operation returns a single status
// item with tlast set. Faults (empty store, fewer than two entries for swap,
// push into a full store) come back as status codes and change nothing. One
// item is in work at a time; the input is ready again as soon as the last
// result has been moved into the output register, even if that result still
// waits. The RAM has one read port, one write port and a registered read
// port. A swap reads the front entry at acceptance, then the second entry,
// writes both back and returns the status item; print-all reads one entry
// per cycle while the output does not stall. No clearing pass is needed
// after reset: only entries below the count are ever read.
// queue_mode is written through the cfg channel, which is always ready, and
// must only be changed while the engine is idle.
module stack_queue_engine
#(
    parameter int DEPTH = sqe_pkg::SQE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // s_tdata: operation [2:0], push_value [34:3], zero fill [39:35]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sqe_pkg::S_TDATA_W-1:0] s_tdata,

    // m_tdata: data [31:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sqe_pkg::DATA_W-1:0]   m_tdata,
    // m_tuser: status [1:0]
    output logic [sqe_pkg::STATUS_W-1:0] m_tuser,
    output logic                         m_tlast,

    // cfg_data: queue_mode [0]
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data
);

    import sqe_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Front-relative offset to physical slot. Both terms are below DEPTH, so
    // one conditional subtract wraps the sum.
    function automatic logic [PTR_W-1:0] slot_at(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Control and payload registers.
    sqe_state_t         state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               mode_reg;
    logic [DATA_W-1:0]  tmp_reg, tmp_next;
    status_t            resp_status_reg, resp_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]  m_data_reg, m_data_next;
    status_t            m_status_reg, m_status_next;
    logic               m_last_reg, m_last_next;

    // RAM port signals.
    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [PTR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;

    // Decoded input item and helpers.
    op_t                in_op;
    logic [DATA_W-1:0]  in_value;
    logic               s_accept;
    logic               out_free;
    logic               is_full;
    logic               is_empty;
    logic               print_last;
    logic [PTR_W-1:0]   head_dec;
    logic [PTR_W-1:0]   slot_second;

    assign in_op       = s_tdata[OP_W-1:0];
    assign in_value    = s_tdata[OP_W+DATA_W-1:OP_W];
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign is_full     = (count_reg == CNT_W'(DEPTH));
    assign is_empty    = (count_reg == '0);
    assign print_last  = (idx_reg == count_reg - CNT_W'(1));
    assign head_dec    = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - PTR_W'(1);
    assign slot_second = slot_at(head_reg, CNT_W'(1));

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_status_reg;
    assign m_tlast   = m_last_reg;

    // Next-state logic: sequencing, pointers and the output register.
    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        tmp_next         = tmp_reg;
        resp_status_next = resp_status_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_status_next    = m_status_reg;
        m_last_next      = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next       = ST_RESP;
                    resp_status_next = STAT_OK;
                    case (in_op)
                        OP_PUSH: begin
                            if (is_full) begin
                                resp_status_next = STAT_FULL;
                            end else begin
                                if (!mode_reg) begin
                                    head_next = head_dec;
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_PRINT_ALL: begin
                            if (is_empty) begin
                                resp_status_next = STAT_EMPTY;
                            end else begin
                                idx_next   = '0;
                                state_next = ST_PRINT;
                            end
                        end
                        OP_PEEK: begin
                            if (is_empty) begin
                                resp_status_next = STAT_EMPTY;
                            end else begin
                                state_next = ST_PEEK;
                            end
                        end
                        OP_POP: begin
                            if (is_empty) begin
                                resp_status_next = STAT_EMPTY;
                            end else begin
                                head_next  = slot_second;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_SWAP: begin
                            if (count_reg < CNT_W'(2)) begin
                                resp_status_next = STAT_SHORT;
                            end else begin
                                state_next = ST_SWAP_A;
                            end
                        end
                        default: begin
                            resp_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_PEEK: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = ram_rdata;
                    m_status_next = STAT_OK;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SWAP_A: begin
                tmp_next   = ram_rdata;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                state_next = ST_SWAP_C;
            end
            ST_SWAP_C: begin
                resp_status_next = STAT_OK;
                state_next       = ST_RESP;
            end
            ST_PRINT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = ram_rdata;
                    m_status_next = STAT_OK;
                    m_last_next   = print_last;
                    if (print_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = '0;
                    m_status_next = resp_status_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM access control. The RAM read is registered, so the read address is
    // set before the cycle in which the state consumes the data.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = head_reg;
        ram_wdata = in_value;
        ram_raddr = head_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (in_op == OP_PUSH) && !is_full) begin
                    ram_we    = 1'b1;
                    ram_waddr = mode_reg ? slot_at(head_reg, count_reg) : head_dec;
                    ram_wdata = in_value;
                end
            end
            ST_SWAP_A: begin
                ram_raddr = slot_second;
            end
            ST_SWAP_B: begin
                // The second entry has just been read; it becomes the front.
                ram_we    = 1'b1;
                ram_waddr = head_reg;
                ram_wdata = ram_rdata;
            end
            ST_SWAP_C: begin
                ram_we    = 1'b1;
                ram_waddr = slot_second;
                ram_wdata = tmp_reg;
            end
            ST_PRINT: begin
                // Hold the address while the output stalls so the read data
                // stays valid; step to the next entry once it is taken.
                if (out_free && !print_last) begin
                    ram_raddr = slot_at(head_reg, idx_reg + CNT_W'(1));
                end else begin
                    ram_raddr = slot_at(head_reg, idx_reg);
                end
            end
            default: begin
                ram_raddr = head_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        tmp_reg         <= tmp_next;
        resp_status_reg <= resp_status_next;
        m_data_reg      <= m_data_next;
        m_status_reg    <= m_status_next;
        m_last_reg      <= m_last_next;
    end

    sqe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    // The count never exceeds the store size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // The head pointer stays inside the buffer.
    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        SUM_W'(head_reg) < SUM_W'(DEPTH))
        else $error("head pointer out of range");

    // Read-only operations never write the RAM.
    a_no_write_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_PRINT) || (state_reg == ST_PEEK)) |-> !ram_we)
        else $error("RAM written during peek or print");

    // The store does not change while it is being printed.
    a_print_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRINT) |=> ($stable(count_reg) && $stable(head_reg)))
        else $error("store changed during print");

    // A swap runs its second read and both write-backs without a break.
    a_swap_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWAP_A) |=> (state_reg == ST_SWAP_B) ##1 (state_reg == ST_SWAP_C))
        else $error("swap sequence broken");
`endif

endmodule

// ===== sim/stack_queue_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_queue_engine_tb
// Self-checking stream testbench for the bounded stack/queue engine.
// ----------------------------------------------------------------------------
// The bench drives push, pop, peek, swap, print-all and unused operation codes
// in both stack and queue mode. It keeps a shadow copy of the circular store
// and works out the result items of every accepted item. Each result item is
// compared field by field in arrival order. A short table covers the empty,
// single-entry and extreme-value cases first. Random phases then fill the
// store to overflow, dump it whole and drain it. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module stack_queue_engine_tb;
    import sqe_pkg::*;

    localparam int HEAD_W       = $clog2(SQE_DEPTH);
    localparam int RANDOM_ITEMS = 130;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE       = 20;

    // Codes the engine does not decode; each one must come back as a plain ok.
    localparam op_t OP_RSVD5 = 3'd5;
    localparam op_t OP_RSVD6 = 3'd6;
    localparam op_t OP_RSVD7 = 3'd7;

    localparam logic STACK_MODE = 1'b0;
    localparam logic QUEUE_MODE = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        status_t           status;
        logic              last;
    } result_t;

    // A pinned item carries a result typed into the table; the monitor checks
    // against it instead of the shadow store's answer.
    typedef struct packed {
        logic    pinned;
        result_t result;
    } pin_t;

    typedef struct packed {
        logic              is_cfg;
        op_t               op;
        logic [DATA_W-1:0] value;
        pin_t              pin;
    } step_t;

    localparam pin_t FREE      = '0;
    localparam pin_t OK_ONLY   = '{1'b1, '{32'h0, STAT_OK, 1'b1}};
    localparam pin_t IS_EMPTY  = '{1'b1, '{32'h0, STAT_EMPTY, 1'b1}};
    localparam pin_t TOO_SHORT = '{1'b1, '{32'h0, STAT_SHORT, 1'b1}};

    localparam int N_DIRECTED = 24;

    // Starts right after reset, so the store is empty and in stack mode.
    localparam step_t DIRECTED [N_DIRECTED] = '{
        '{1'b0, OP_PEEK,      32'h0000_0000, IS_EMPTY},
        '{1'b0, OP_POP,       32'hFFFF_FFFF, IS_EMPTY},
        '{1'b0, OP_PRINT_ALL, 32'h0000_0000, IS_EMPTY},
        '{1'b0, OP_SWAP,      32'h0000_0000, TOO_SHORT},
        '{1'b0, OP_RSVD5,     32'hFFFF_FFFF, OK_ONLY},
        '{1'b0, OP_RSVD7,     32'h0000_0000, OK_ONLY},
        '{1'b0, OP_PUSH,      32'h8000_0000, OK_ONLY},
        '{1'b0, OP_SWAP,      32'h0000_0000, TOO_SHORT},
        '{1'b0, OP_PEEK,      32'h0000_0000, '{1'b1, '{32'h8000_0000, STAT_OK, 1'b1}}},
        '{1'b0, OP_PUSH,      32'h7FFF_FFFF, OK_ONLY},
        '{1'b0, OP_PEEK,      32'h0000_0000, '{1'b1, '{32'h7FFF_FFFF, STAT_OK, 1'b1}}},
        '{1'b0, OP_SWAP,      32'h0000_0000, OK_ONLY},
        '{1'b0, OP_PEEK,      32'h0000_0000, '{1'b1, '{32'h8000_0000, STAT_OK, 1'b1}}},
        '{1'b0, OP_PUSH,      32'hFFFF_FFFF, OK_ONLY},
        '{1'b0, OP_PRINT_ALL, 32'h0000_0000, FREE},
        '{1'b0, OP_RSVD6,     32'h5A5A_5A5A, OK_ONLY},
        '{1'b1, OP_PUSH,      32'h0000_0001, FREE},
        '{1'b0, OP_PUSH,      32'h0000_0000, OK_ONLY},
        '{1'b0, OP_PUSH,      32'h5555_5555, OK_ONLY},
        '{1'b0, OP_PEEK,      32'h0000_0000, FREE},
        '{1'b0, OP_PRINT_ALL, 32'h0000_0000, FREE},
        '{1'b0, OP_POP,       32'h0000_0000, OK_ONLY},
        '{1'b0, OP_SWAP,      32'h0000_0000, FREE},
        '{1'b0, OP_PRINT_ALL, 32'h0000_0000, FREE}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: operation [2:0], push_value [34:3], zero fill [39:35]
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata: data [31:0]
    logic [DATA_W-1:0]     m_tdata;
    // m_tuser: status [1:0]
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_data;

    // Shadow of the engine's store, pointer, count and mode.
    logic [DATA_W-1:0]     shadow_entries [SQE_DEPTH];
    logic [HEAD_W-1:0]     shadow_head       = '0;
    logic [HEAD_W:0]       shadow_count      = '0;
    logic                  shadow_queue_mode = STACK_MODE;

    result_t               awaited_results [$];
    pin_t                  item_pins [$];

    // Entry count as the sender sees it, used to shape fill and drain phases.
    int                    fill_level      = 0;
    int                    items_sent      = 0;
    int                    results_checked = 0;
    int                    overflows_sent  = 0;
    int                    n_fail          = 0;
    int                    idle_cycles     = 0;
    bit                    no_gaps         = 1'b0;

    result_t               got_result;
    result_t               want_result;
    pin_t                  accepted_pin;
    logic                  progress;

    stack_queue_engine #(
        .DEPTH(SQE_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Gap length for either side: mostly none or a few cycles, now and then a
    // long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Works out the result items of one accepted item and advances the shadow
    // store. A pinned item replaces the single predicted result with the
    // typed-in one.
    task automatic apply_operation(input op_t op, input logic [DATA_W-1:0] value,
                                   input pin_t pin);
        result_t           r;
        logic [HEAD_W-1:0] slot_a;
        logic [HEAD_W-1:0] slot_b;
        logic [DATA_W-1:0] held;
        int                i;
        r = '{data: '0, status: STAT_OK, last: 1'b1};
        case (op)
            OP_PUSH: begin
                if (shadow_count >= SQE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    if (shadow_queue_mode) begin
                        shadow_entries[shadow_head + HEAD_W'(shadow_count)] = value;
                    end else begin
                        shadow_head = shadow_head - 1'b1;
                        shadow_entries[shadow_head] = value;
                    end
                    shadow_count = shadow_count + 1'b1;
                end
                awaited_results.push_back(r);
            end
            OP_PRINT_ALL: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                    awaited_results.push_back(r);
                end else begin
                    for (i = 0; i < shadow_count; i++) begin
                        r.data = shadow_entries[shadow_head + HEAD_W'(i)];
                        r.last = (i == shadow_count - 1);
                        awaited_results.push_back(r);
                    end
                end
            end
            OP_PEEK: begin
                if (shadow_count == 0)
                    r.status = STAT_EMPTY;
                else
                    r.data = shadow_entries[shadow_head];
                awaited_results.push_back(r);
            end
            OP_POP: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    shadow_head  = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
                awaited_results.push_back(r);
            end
            OP_SWAP: begin
                if (shadow_count < 2) begin
                    r.status = STAT_SHORT;
                end else begin
                    slot_a = shadow_head;
                    slot_b = shadow_head + 1'b1;
                    held   = shadow_entries[slot_a];
                    shadow_entries[slot_a] = shadow_entries[slot_b];
                    shadow_entries[slot_b] = held;
                end
                awaited_results.push_back(r);
            end
            default: begin
                awaited_results.push_back(r);
            end
        endcase
        if (pin.pinned)
            awaited_results[awaited_results.size() - 1] = pin.result;
    endtask

    // Offers one item after a random gap and returns at the edge where it is
    // taken. tvalid stays high on return; the next call either replaces the
    // item or lowers tvalid.
    task automatic send_item(input op_t op, input logic [DATA_W-1:0] value,
                             input pin_t pin);
        int gap;
        gap = no_gaps ? 0 : idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - DATA_W - OP_W){1'b0}}, value, op};
        item_pins.push_back(pin);
        if (op == OP_PUSH && fill_level == SQE_DEPTH)
            overflows_sent++;
        if (op == OP_PUSH && fill_level < SQE_DEPTH)
            fill_level++;
        else if (op == OP_POP && fill_level > 0)
            fill_level--;
        items_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Lets every awaited result arrive, then a few more cycles so that the
    // engine is surely idle.
    task automatic drain_results(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // The mode register may only change while the engine is idle.
    task automatic write_queue_mode(input logic mode);
        drain_results(4);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: runs of ready, broken by stalls of random length. Long runs
    // give stretches without any back-pressure.
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(40, 80)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            begin
                int stall;
                stall = idle_length();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    // Monitor: takes mode writes and items into the shadow store and checks
    // each result item against the oldest one still awaited. Results are
    // handled before items; a result never belongs to an item taken at the
    // same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            progress = 1'b0;
            if (cfg_valid && cfg_ready) begin
                shadow_queue_mode = cfg_data;
                progress = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                progress   = 1'b1;
                got_result = '{data: m_tdata, status: m_tuser, last: m_tlast};
                if (awaited_results.size() == 0) begin
                    n_fail++;
                    $display("%0t: result item with none awaited: data %h status %0d last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want_result = awaited_results.pop_front();
                    results_checked++;
                    if (got_result.data !== want_result.data) begin
                        n_fail++;
                        $display("%0t: data mismatch, expected %h, actual %h",
                                 $time, want_result.data, got_result.data);
                    end
                    if (got_result.status !== want_result.status) begin
                        n_fail++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want_result.status, got_result.status);
                    end
                    if (got_result.last !== want_result.last) begin
                        n_fail++;
                        $display("%0t: last mismatch, expected %0b, actual %0b",
                                 $time, want_result.last, got_result.last);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                progress     = 1'b1;
                accepted_pin = item_pins.pop_front();
                apply_operation(s_tdata[OP_W-1:0], s_tdata[OP_W +: DATA_W], accepted_pin);
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: ends the run when nothing has moved on any channel for too
    // long.
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Run stalled at %0t with %0d results still awaited.",
                 $time, awaited_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus: reset, the directed table, then random phases.
    initial begin
        int  phase;
        int  kind;
        int  k;
        int  r;
        op_t op;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= STACK_MODE;
        aresetn   <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn   <= 1'b1;
        @(posedge aclk);

        // Directed table. A mode-write row first waits for the engine to idle.
        for (k = 0; k < N_DIRECTED; k++) begin
            if (DIRECTED[k].is_cfg)
                write_queue_mode(DIRECTED[k].value[0]);
            else
                send_item(DIRECTED[k].op, DIRECTED[k].value, DIRECTED[k].pin);
        end

        // Random phases. The first three fill, drain and fill again so that
        // overflow and whole-store dumps are reached at least in stack mode; the rest
        // pick a phase at random. Every phase starts with a mode write.
        phase = 0;
        while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
            if (phase == 0)
                write_queue_mode(STACK_MODE);
            else if (phase == 1)
                write_queue_mode(QUEUE_MODE);
            else
                write_queue_mode(1'($urandom_range(0, 1)));
            no_gaps = ($urandom_range(0, 3) == 0);
            kind    = (phase < 3) ? 1 + phase % 2 : $urandom_range(0, 2);
            case (kind)
                0: begin
                    // Mixed operations, pushes slightly favored.
                    repeat ($urandom_range(12, 24)) begin
                        r = $urandom_range(0, 99);
                        if (r < 35)      op = OP_PUSH;
                        else if (r < 55) op = OP_POP;
                        else if (r < 67) op = OP_PEEK;
                        else if (r < 79) op = OP_SWAP;
                        else if (r < 92) op = OP_PRINT_ALL;
                        else             op = OP_RSVD5 + op_t'($urandom_range(0, 2));
                        send_item(op, random_word(), FREE);
                    end
                end
                1: begin
                    // Fill up, push past the top, then dump the full store.
                    while (fill_level < SQE_DEPTH) begin
                        if ($urandom_range(0, 9) == 0)
                            send_item($urandom_range(0, 1) ? OP_PEEK : OP_SWAP,
                                      random_word(), FREE);
                        else
                            send_item(OP_PUSH, random_word(), FREE);
                    end
                    repeat ($urandom_range(1, 2)) send_item(OP_PUSH, random_word(), FREE);
                    send_item(OP_PRINT_ALL, random_word(), FREE);
                    send_item(OP_SWAP, random_word(), FREE);
                    send_item(OP_PEEK, random_word(), FREE);
                    send_item(OP_POP, random_word(), FREE);
                end
                default: begin
                    // Drain to empty, then hit the empty-store cases again.
                    while (fill_level > 0) begin
                        r = $urandom_range(0, 99);
                        if (r < 80)      op = OP_POP;
                        else if (r < 88) op = OP_PEEK;
                        else if (r < 95) op = OP_SWAP;
                        else             op = OP_PRINT_ALL;
                        send_item(op, random_word(), FREE);
                    end
                    send_item(OP_POP, random_word(), FREE);
                    send_item(OP_PEEK, random_word(), FREE);
                    send_item(OP_PRINT_ALL, random_word(), FREE);
                    send_item(OP_SWAP, random_word(), FREE);
                end
            endcase
            phase++;
        end

        drain_results(SETTLE);
        if (awaited_results.size() != 0) begin
            n_fail++;
            $display("%0t: %0d result items never arrived", $time, awaited_results.size());
        end

        $display("Sent %0d items over %0d random phases in stack and queue mode, %0d of them",
                 items_sent, phase, overflows_sent);
        $display("pushes at a full store; checked %0d result items, %0d mismatches.",
                 results_checked, n_fail);
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== stack_queue_engine.f =====
hdl/sqe_pkg.sv
hdl/sqe_ram.sv
hdl/stack_queue_engine.sv
sim/stack_queue_engine_tb.sv
